// ===== hdl/tgns_pkg.sv =====
// shared types, constants and reset values for the tile grid smoother
`default_nettype none

package tgns_pkg;

    // default grid storage limits
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    // fixed field widths
    localparam int KIND_W      = 2;
    localparam int COORD_W     = 6;
    localparam int SAMPLE_W    = 7;
    localparam int TILE_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;
    localparam int PASS_W      = 4;
    localparam int SUM_W       = 5;

    // configuration reset values
    localparam logic [SAMPLE_W-1:0]   STONE_THR_RST  = 7'd70;
    localparam logic [SAMPLE_W-1:0]   DIRT_THR_RST   = 7'd40;
    localparam logic [PASS_W-1:0]     PASS_COUNT_RST = 4'd4;
    localparam logic [CFG_DATA_W-1:0] GRID_W_RST     = 7'd64;
    localparam logic [CFG_DATA_W-1:0] GRID_H_RST     = 7'd64;

    // neighbour sum limits
    localparam logic [SUM_W-1:0] SUM_STONE_LIM = 5'd10;
    localparam logic [SUM_W-1:0] SUM_DIRT_LIM  = 5'd5;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_SMOOTH = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    typedef enum logic [TILE_W-1:0] {
        TILE_EMPTY = 2'd0,
        TILE_DIRT  = 2'd1,
        TILE_STONE = 2'd2
    } t_tile;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STONE_THR   = 3'd0,
        CFG_DIRT_THR    = 3'd1,
        CFG_PASS_COUNT  = 3'd2,
        CFG_GRID_WIDTH  = 3'd3,
        CFG_GRID_HEIGHT = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SMOOTH,
        ST_HOLD
    } t_top_state;

    typedef enum logic [1:0] {
        SM_IDLE,
        SM_READ,
        SM_LAST
    } t_sm_state;

    typedef struct packed {
        logic              start;
        logic [PASS_W-1:0] passes;
    } t_smooth_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_smooth_stat;

endpackage

`default_nettype wire

// ===== hdl/tgns_cmd_if.sv =====
// command channel: kind, coordinates and sample
`default_nettype none

interface tgns_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [tgns_pkg::KIND_W-1:0]   kind;
    logic [tgns_pkg::COORD_W-1:0]  column;
    logic [tgns_pkg::COORD_W-1:0]  row;
    logic [tgns_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output kind, output column, output row, output sample,
                    input ready);
    modport sink (input valid, input kind, input column, input row, input sample,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/tgns_res_if.sv =====
// result channel: tile class and completed kind
`default_nettype none

interface tgns_res_if;
    logic                        valid;
    logic                        ready;
    logic [tgns_pkg::TILE_W-1:0] tile_class;
    logic [tgns_pkg::KIND_W-1:0] done_kind;

    modport source (output valid, output tile_class, output done_kind, input ready);
    modport sink (input valid, input tile_class, input done_kind, output ready);
endinterface

`default_nettype wire

// ===== hdl/tile_grid_neighbour_smoother_top.sv =====
// tile grid smoother top: command decode, configuration, result buffering
//
// channel   dir  handshake      payload
// i_cmd     in   valid/ready    kind, column, row, sample
// o_res     out  valid/ready    tile_class, done_kind
// i_cfg_*   in   write enable   index, data (no read-back)
//
// load and unknown kinds can follow back to back while the output slot is free
// read goes through the tile memory's registered read port, then the output register
// smooth visits every tile of the used grid once per pass: each tile reads
// its 8 neighbours one per cycle from the single read port, then writes back
// reset clears control and configuration only; the tile store is not cleared
// one item may be accepted while a result waits; after that input stalls
`default_nettype none

module tile_grid_neighbour_smoother_top #(
    parameter int MAX_WIDTH  = tgns_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tgns_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tgns_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [tgns_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tgns_cmd_if.sink                              i_cmd,
    tgns_res_if.source                            o_res
);

    import tgns_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 2 ** AW;

    // configuration registers
    logic [SAMPLE_W-1:0]   r_stone_thr;
    logic [SAMPLE_W-1:0]   r_dirt_thr;
    logic [PASS_W-1:0]     r_pass_count;
    logic [CFG_DATA_W-1:0] r_grid_w;
    logic [CFG_DATA_W-1:0] r_grid_h;

    // control and result registers
    t_top_state        r_state, n_state;
    logic              r_inside, n_inside;
    logic              r_out_valid, n_out_valid;
    logic [TILE_W-1:0] r_out_tile, n_out_tile;
    logic [KIND_W-1:0] r_out_kind, n_out_kind;
    logic [TILE_W-1:0] r_hold_tile, n_hold_tile;
    logic [KIND_W-1:0] r_hold_kind, n_hold_kind;

    logic [XW:0]       used_w;
    logic [YW:0]       used_h;
    logic              cmd_acc;
    logic              cmd_inside;
    logic [AW-1:0]     cmd_addr;
    logic [TILE_W-1:0] cmd_class;
    logic              slot_free;
    logic              res_go;
    logic [TILE_W-1:0] res_tile;
    logic [KIND_W-1:0] res_kind;
    logic              top_we;
    logic              top_re;

    t_smooth_ctrl      sm_ctrl;
    t_smooth_stat      sm_stat;
    logic              sm_re;
    logic [AW-1:0]     sm_raddr;
    logic              sm_we;
    logic [AW-1:0]     sm_waddr;
    logic [TILE_W-1:0] sm_wdata;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [TILE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [TILE_W-1:0] ram_rdata;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stone_thr  <= STONE_THR_RST;
            r_dirt_thr   <= DIRT_THR_RST;
            r_pass_count <= PASS_COUNT_RST;
            r_grid_w     <= GRID_W_RST;
            r_grid_h     <= GRID_H_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_STONE_THR:   r_stone_thr  <= i_cfg_data;
                CFG_DIRT_THR:    r_dirt_thr   <= i_cfg_data;
                CFG_PASS_COUNT:  r_pass_count <= i_cfg_data[PASS_W-1:0];
                CFG_GRID_WIDTH:  r_grid_w     <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_h     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // grid size in use, clamped to 1 .. max
    always_comb begin
        if (r_grid_w == '0) begin
            used_w = (XW+1)'(1);
        end else if (int'(r_grid_w) > MAX_WIDTH) begin
            used_w = (XW+1)'(MAX_WIDTH);
        end else begin
            used_w = (XW+1)'(r_grid_w);
        end
        if (r_grid_h == '0) begin
            used_h = (YW+1)'(1);
        end else if (int'(r_grid_h) > MAX_HEIGHT) begin
            used_h = (YW+1)'(MAX_HEIGHT);
        end else begin
            used_h = (YW+1)'(r_grid_h);
        end
    end

    // command decode helpers
    always_comb begin
        cmd_inside = (int'(i_cmd.column) < int'(used_w)) && (int'(i_cmd.row) < int'(used_h));
        cmd_addr   = {XW'(i_cmd.column), YW'(i_cmd.row)};
        if (i_cmd.sample > r_stone_thr) begin
            cmd_class = TILE_STONE;
        end else if (i_cmd.sample > r_dirt_thr) begin
            cmd_class = TILE_DIRT;
        end else begin
            cmd_class = TILE_EMPTY;
        end
    end

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign slot_free   = !r_out_valid || o_res.ready;

    // item control and result routing
    always_comb begin
        n_state        = r_state;
        n_inside       = r_inside;
        n_hold_tile    = r_hold_tile;
        n_hold_kind    = r_hold_kind;
        n_out_valid    = r_out_valid && !o_res.ready;
        n_out_tile     = r_out_tile;
        n_out_kind     = r_out_kind;
        res_go         = 1'b0;
        res_tile       = TILE_EMPTY;
        res_kind       = i_cmd.kind;
        top_we         = 1'b0;
        top_re         = 1'b0;
        sm_ctrl.start  = 1'b0;
        sm_ctrl.passes = r_pass_count;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_acc) begin
                    unique case (t_kind'(i_cmd.kind))
                        KIND_LOAD: begin
                            top_we   = cmd_inside;
                            res_go   = 1'b1;
                            res_tile = cmd_class;
                        end
                        KIND_SMOOTH: begin
                            sm_ctrl.start = 1'b1;
                            n_state       = ST_SMOOTH;
                        end
                        KIND_READ: begin
                            top_re   = 1'b1;
                            n_inside = cmd_inside;
                            n_state  = ST_READ;
                        end
                        default: begin
                            res_go = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_go   = 1'b1;
                res_tile = r_inside ? ram_rdata : TILE_EMPTY;
                res_kind = KIND_READ;
            end
            ST_SMOOTH: begin
                res_go   = sm_stat.done;
                res_kind = KIND_SMOOTH;
            end
            ST_HOLD: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_tile  = r_hold_tile;
                    n_out_kind  = r_hold_kind;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // a finished result goes out, or waits in the hold register
        if (res_go) begin
            if (slot_free) begin
                n_out_valid = 1'b1;
                n_out_tile  = res_tile;
                n_out_kind  = res_kind;
                n_state     = ST_IDLE;
            end else begin
                n_hold_tile = res_tile;
                n_hold_kind = res_kind;
                n_state     = ST_HOLD;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_inside    <= n_inside;
        r_out_tile  <= n_out_tile;
        r_out_kind  <= n_out_kind;
        r_hold_tile <= n_hold_tile;
        r_hold_kind <= n_hold_kind;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.tile_class = r_out_tile;
    assign o_res.done_kind  = r_out_kind;

    // smoothing sequencer
    tgns_smooth #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_smooth (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (sm_ctrl),
        .o_stat        (sm_stat),
        .i_used_width  (used_w),
        .i_used_height (used_h),
        .o_rd_en       (sm_re),
        .o_rd_addr     (sm_raddr),
        .i_rd_data     (ram_rdata),
        .o_wr_en       (sm_we),
        .o_wr_addr     (sm_waddr),
        .o_wr_data     (sm_wdata)
    );

    // memory port sharing: the sequencer owns the ports while busy
    always_comb begin
        ram_we    = top_we || sm_we;
        ram_re    = top_re || sm_re;
        ram_waddr = sm_stat.busy ? sm_waddr : cmd_addr;
        ram_wdata = sm_stat.busy ? sm_wdata : cmd_class;
        ram_raddr = sm_stat.busy ? sm_raddr : cmd_addr;
    end

    // tile store
    tgns_ram #(
        .WIDTH (TILE_W),
        .DEPTH (DEPTH)
    ) u_tile_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // a held result implies the output register is full
    a_hold_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD) |-> r_out_valid)
        else $error("result held while output register empty");

    // the sequencer only finishes while the top waits for it
    a_done_in_smooth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sm_stat.done |-> (r_state == ST_SMOOTH))
        else $error("smooth done outside smooth state");

    // command accesses never collide with the sequencer on the memory
    a_no_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (top_we || top_re) |-> !sm_stat.busy)
        else $error("memory access while sequencer busy");

    // a load with a free output slot shows its result next cycle
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && (i_cmd.kind == KIND_LOAD) && slot_free)
        |=> (r_out_valid && (r_out_kind == KIND_LOAD)))
        else $error("load result missing");

endmodule

`default_nettype wire

// ===== hdl/tgns_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none

module tgns_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/tgns_smooth.sv =====
// smoothing sequencer: reads 8 neighbours per tile and writes the new class in place
`default_nettype none

module tgns_smooth #(
    parameter int MAX_WIDTH  = tgns_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tgns_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire tgns_pkg::t_smooth_ctrl                            i_ctrl,
    output tgns_pkg::t_smooth_stat                                 o_stat,
    input  wire logic [$clog2(MAX_WIDTH):0]                        i_used_width,
    input  wire logic [$clog2(MAX_HEIGHT):0]                       i_used_height,
    output logic                                                   o_rd_en,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0]        o_rd_addr,
    input  wire logic [tgns_pkg::TILE_W-1:0]                       i_rd_data,
    output logic                                                   o_wr_en,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0]        o_wr_addr,
    output logic [tgns_pkg::TILE_W-1:0]                            o_wr_data
);

    import tgns_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    // neighbour offsets, coded as offset plus one
    localparam logic [1:0] NB_DX [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] NB_DY [8] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};

    t_sm_state         r_state, n_state;
    logic [XW-1:0]     r_x, n_x;
    logic [YW-1:0]     r_y, n_y;
    logic [2:0]        r_k, n_k;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic              r_off, n_off;
    logic [PASS_W-1:0] r_pass, n_pass;
    logic [PASS_W-1:0] r_passes, n_passes;
    logic              r_done, n_done;

    logic [XW:0]       nx;
    logic [YW:0]       ny;
    logic              nb_off;
    logic [SUM_W-1:0]  w_in;
    logic [SUM_W-1:0]  sum_total;
    logic              last_row;
    logic              last_col;
    logic              last_pass;

    // neighbour address; wrap below zero lands above the used size
    always_comb begin
        nx        = (XW+1)'(r_x) + (XW+1)'(NB_DX[r_k]) - (XW+1)'(1);
        ny        = (YW+1)'(r_y) + (YW+1)'(NB_DY[r_k]) - (YW+1)'(1);
        nb_off    = (nx >= i_used_width) || (ny >= i_used_height);
        o_rd_addr = {nx[XW-1:0], ny[YW-1:0]};
    end

    // weight of the neighbour whose data arrives this cycle
    always_comb begin
        if (r_off) begin
            w_in = SUM_W'(2);
        end else if (i_rd_data == TILE_STONE) begin
            w_in = SUM_W'(2);
        end else if (i_rd_data == TILE_DIRT) begin
            w_in = SUM_W'(1);
        end else begin
            w_in = '0;
        end
        sum_total = r_sum + w_in;
    end

    // new class and write address
    always_comb begin
        o_wr_addr = {r_x, r_y};
        if (sum_total > SUM_STONE_LIM) begin
            o_wr_data = TILE_STONE;
        end else if (sum_total > SUM_DIRT_LIM) begin
            o_wr_data = TILE_DIRT;
        end else begin
            o_wr_data = TILE_EMPTY;
        end
    end

    // scan position limits
    always_comb begin
        last_row  = ((YW+1)'(r_y) + (YW+1)'(1)) == i_used_height;
        last_col  = ((XW+1)'(r_x) + (XW+1)'(1)) == i_used_width;
        last_pass = (r_pass + PASS_W'(1)) == r_passes;
    end

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_y      = r_y;
        n_k      = r_k;
        n_sum    = r_sum;
        n_off    = r_off;
        n_pass   = r_pass;
        n_passes = r_passes;
        n_done   = 1'b0;
        o_rd_en  = 1'b0;
        o_wr_en  = 1'b0;
        unique case (r_state)
            SM_IDLE: begin
                if (i_ctrl.start) begin
                    n_passes = i_ctrl.passes;
                    n_pass   = '0;
                    n_x      = '0;
                    n_y      = '0;
                    n_k      = '0;
                    if (i_ctrl.passes == '0) begin
                        n_done = 1'b1;
                    end else begin
                        n_state = SM_READ;
                    end
                end
            end
            SM_READ: begin
                o_rd_en = 1'b1;
                n_off   = nb_off;
                n_sum   = (r_k == '0) ? '0 : sum_total;
                n_k     = r_k + 3'd1;
                if (r_k == 3'd7) begin
                    n_state = SM_LAST;
                end
            end
            SM_LAST: begin
                o_wr_en = 1'b1;
                n_k     = '0;
                n_state = SM_READ;
                if (!last_row) begin
                    n_y = r_y + YW'(1);
                end else begin
                    n_y = '0;
                    if (!last_col) begin
                        n_x = r_x + XW'(1);
                    end else begin
                        n_x = '0;
                        if (last_pass) begin
                            n_done  = 1'b1;
                            n_state = SM_IDLE;
                        end else begin
                            n_pass = r_pass + PASS_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = SM_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SM_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // scan and accumulator registers
    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_k      <= n_k;
        r_sum    <= n_sum;
        r_off    <= n_off;
        r_pass   <= n_pass;
        r_passes <= n_passes;
    end

    assign o_stat.busy = (r_state != SM_IDLE);
    assign o_stat.done = r_done;

endmodule

`default_nettype wire
